### hw/rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants for the contiguous fit allocator
// Transaction payloads, table entry layout, command, policy and status codes.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int ADDR_BITS    = 20;
  localparam int LEN_W        = ADDR_BITS + 1;
  localparam int OWNER_W      = 8;
  localparam int MAX_SEG_DEF  = 16;
  localparam int LIST_LIMIT   = 16;

  localparam logic [LEN_W-1:0] MEM_SIZE_MAX = LEN_W'(1) << ADDR_BITS;
  localparam logic [LEN_W-1:0] MEM_SIZE_RST = MEM_SIZE_MAX;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;
  localparam logic [1:0] CMD_LIST    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [OWNER_W-1:0] owner_id;
    logic [LEN_W-1:0]   request_size;
    logic [1:0]         fit_policy;
  } in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] seg_start;
    logic [ADDR_BITS-1:0] seg_end;
    logic [OWNER_W-1:0]   seg_owner;
    logic                 seg_in_use;
    logic                 last_result;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     len;
    logic [OWNER_W-1:0]   owner;
    logic                 used;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REQ_SCAN, S_REQ_OPEN, S_REQ_WLO, S_REQ_WHI,
    S_REL_SCAN, S_REL_NEXT, S_REL_CLOSE, S_REL_PREV,
    S_CMP_SCAN, S_CMP_TOP, S_LIST, S_EMIT
  } state_t;

  // last address of a segment, wrapped to the address width
  function automatic logic [ADDR_BITS-1:0] seg_last(logic [ADDR_BITS-1:0] base,
                                                    logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sum;
    sum = LEN_W'(base) + len - LEN_W'(1);
    return sum[ADDR_BITS-1:0];
  endfunction

endpackage

### hw/rtl/contiguous_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_unit: segment table allocator
// Address-ordered segment table with fit search, split, merge, compaction
// and listing, run by a small sequencer over one table access per cycle.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_SEGMENTS segments tiling [0, memory_size). Each
// accepted transaction is one command; the block holds in_stall high until
// the command has finished and its last result sits in the output register.
// The sequencer reads one table entry and writes one per cycle unless the
// output stalls, so timing follows the segment count N. A request scans, then
// shifts entries up on a split and writes the pick; a release scans, merges
// free neighbours and shifts entries down; a compaction packs used segments
// and adds a top hole if space is left; a listing emits segments in turn.
// Writing cfg_wr_data resets the table to one hole of that size (0 acts as 1,
// values above 2^20 saturate); write it only while idle.
module contiguous_fit_allocator_unit #(
  parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEG_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cfa_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cfa_pkg::out_t              out_data,
  input  logic                       cfg_wr_en,
  input  logic [cfa_pkg::LEN_W-1:0]  cfg_wr_data
);
  import cfa_pkg::*;

  localparam int IW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW     = $clog2(MAX_SEGMENTS + 1);
  localparam int LIST_N = (MAX_SEGMENTS < LIST_LIMIT) ? MAX_SEGMENTS : LIST_LIMIT;

  // segment table, one read and one write port per cycle
  entry_t tbl_r [MAX_SEGMENTS];

  state_t state_r, state_nxt;
  in_t    cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [ADDR_BITS-1:0] pick_base_r, pick_base_nxt;
  logic [LEN_W-1:0] pick_len_r, pick_len_nxt;
  logic found_r, found_nxt;
  logic close_lo_r, close_lo_nxt;
  logic [LEN_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0] mem_size_r;
  out_t res_r, res_nxt;
  out_t out_r;
  logic out_valid_r;

  logic [IW-1:0] rd_idx;
  entry_t rd_ent;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  entry_t wr_ent;
  logic out_ld;
  out_t out_ld_data;
  logic out_free;
  logic in_acc;
  logic [LEN_W-1:0] cfg_sat;
  logic hit, better;
  logic [CW-1:0] nxt_idx, prv_idx, list_n;
  logic [LEN_W-1:0] sum_len;
  logic [LEN_W-1:0] hi_base;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_ent    = tbl_r[rd_idx];
  assign list_n    = (cnt_r > CW'(LIST_N)) ? CW'(LIST_N) : cnt_r;

  // clamp the written size into [1, 2^ADDR_BITS]
  always_comb begin
    cfg_sat = cfg_wr_data;
    if (cfg_sat == '0) cfg_sat = LEN_W'(1);
    if (cfg_sat > MEM_SIZE_MAX) cfg_sat = MEM_SIZE_MAX;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    pick_nxt      = pick_r;
    pick_base_nxt = pick_base_r;
    pick_len_nxt  = pick_len_r;
    found_nxt     = found_r;
    close_lo_nxt  = close_lo_r;
    addr_nxt      = addr_r;
    res_nxt       = res_r;
    rd_idx        = i_r[IW-1:0];
    wr_en         = 1'b0;
    wr_idx        = '0;
    wr_ent        = '0;
    out_ld        = 1'b0;
    out_ld_data   = res_r;
    hit           = 1'b0;
    better        = 1'b0;
    nxt_idx       = CW'(pick_r) + CW'(1);
    prv_idx       = j_r - CW'(1);
    sum_len       = '0;
    hi_base       = LEN_W'(pick_base_r) + cmd_r.request_size;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_data;
          i_nxt     = '0;
          w_nxt     = '0;
          found_nxt = 1'b0;
          addr_nxt  = '0;
          res_nxt   = '0;
          res_nxt.last_result = 1'b1;
          unique case (in_data.command)
            CMD_REQUEST: begin
              if (in_data.request_size == '0) begin
                res_nxt.status = ST_ZERO;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_REQ_SCAN;
              end
            end
            CMD_RELEASE: state_nxt = S_REL_SCAN;
            CMD_COMPACT: state_nxt = S_CMP_SCAN;
            default:     state_nxt = S_LIST;
          endcase
        end
      end

      S_REQ_SCAN: begin
        if (i_r == cnt_r) begin
          if (!found_r) begin
            res_nxt.status = ST_NO_SPACE;
            state_nxt = S_EMIT;
          end else if (pick_len_r != cmd_r.request_size) begin
            if (cnt_r == CW'(MAX_SEGMENTS)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_EMIT;
            end else begin
              j_nxt = cnt_r;
              state_nxt = S_REQ_OPEN;
            end
          end else begin
            state_nxt = S_REQ_WLO;
          end
        end else begin
          hit    = !rd_ent.used && (rd_ent.len >= cmd_r.request_size);
          better = !found_r
                   || (cmd_r.fit_policy == POL_BEST  && rd_ent.len < pick_len_r)
                   || (cmd_r.fit_policy == POL_WORST && rd_ent.len > pick_len_r);
          i_nxt = i_r + CW'(1);
          if (hit && better) begin
            pick_nxt      = i_r[IW-1:0];
            pick_base_nxt = rd_ent.base;
            pick_len_nxt  = rd_ent.len;
            found_nxt     = 1'b1;
            // first fit (and the unused code) stops at the first hit
            if (!found_r && cmd_r.fit_policy != POL_BEST
                && cmd_r.fit_policy != POL_WORST) begin
              i_nxt = cnt_r;
            end
          end
        end
      end

      S_REQ_OPEN: begin
        // shift entries above the pick up by one
        if (j_r == CW'(pick_r)) begin
          cnt_nxt = cnt_r + CW'(1);
          state_nxt = S_REQ_WLO;
        end else begin
          rd_idx = prv_idx[IW-1:0];
          wr_en  = 1'b1;
          wr_idx = j_r[IW-1:0];
          wr_ent = rd_ent;
          j_nxt  = prv_idx;
        end
      end

      S_REQ_WLO: begin
        wr_en        = 1'b1;
        wr_idx       = pick_r;
        wr_ent.base  = pick_base_r;
        wr_ent.len   = cmd_r.request_size;
        wr_ent.owner = cmd_r.owner_id;
        wr_ent.used  = 1'b1;
        res_nxt.status     = ST_OK;
        res_nxt.seg_start  = pick_base_r;
        res_nxt.seg_end    = seg_last(pick_base_r, cmd_r.request_size);
        res_nxt.seg_owner  = cmd_r.owner_id;
        res_nxt.seg_in_use = 1'b1;
        state_nxt = (pick_len_r != cmd_r.request_size) ? S_REQ_WHI : S_EMIT;
      end

      S_REQ_WHI: begin
        wr_en       = 1'b1;
        wr_idx      = nxt_idx[IW-1:0];
        wr_ent.base = hi_base[ADDR_BITS-1:0];
        wr_ent.len  = pick_len_r - cmd_r.request_size;
        state_nxt   = S_EMIT;
      end

      S_REL_SCAN: begin
        if (i_r == cnt_r) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt = S_EMIT;
        end else if (rd_ent.used && rd_ent.owner == cmd_r.owner_id) begin
          pick_nxt      = i_r[IW-1:0];
          pick_base_nxt = rd_ent.base;
          pick_len_nxt  = rd_ent.len;
          wr_en         = 1'b1;
          wr_idx        = i_r[IW-1:0];
          wr_ent.base   = rd_ent.base;
          wr_ent.len    = rd_ent.len;
          res_nxt.status    = ST_OK;
          res_nxt.seg_start = rd_ent.base;
          res_nxt.seg_end   = seg_last(rd_ent.base, rd_ent.len);
          res_nxt.seg_owner = cmd_r.owner_id;
          state_nxt = S_REL_NEXT;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end

      S_REL_NEXT: begin
        state_nxt = S_REL_PREV;
        if (nxt_idx < cnt_r) begin
          rd_idx = nxt_idx[IW-1:0];
          if (!rd_ent.used) begin
            sum_len      = pick_len_r + rd_ent.len;
            wr_en        = 1'b1;
            wr_idx       = pick_r;
            wr_ent.base  = pick_base_r;
            wr_ent.len   = sum_len;
            pick_len_nxt = sum_len;
            j_nxt        = nxt_idx;
            close_lo_nxt = 1'b0;
            state_nxt    = S_REL_CLOSE;
          end
        end
      end

      S_REL_CLOSE: begin
        // drop entry j, shifting higher entries down
        if (j_r + CW'(1) >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = close_lo_r ? S_EMIT : S_REL_PREV;
        end else begin
          rd_idx = IW'(j_r + CW'(1));
          wr_en  = 1'b1;
          wr_idx = j_r[IW-1:0];
          wr_ent = rd_ent;
          j_nxt  = j_r + CW'(1);
        end
      end

      S_REL_PREV: begin
        state_nxt = S_EMIT;
        if (pick_r != '0) begin
          rd_idx = pick_r - IW'(1);
          if (!rd_ent.used) begin
            wr_en        = 1'b1;
            wr_idx       = pick_r - IW'(1);
            wr_ent.base  = rd_ent.base;
            wr_ent.len   = rd_ent.len + pick_len_r;
            j_nxt        = CW'(pick_r);
            close_lo_nxt = 1'b1;
            state_nxt    = S_REL_CLOSE;
          end
        end
      end

      S_CMP_SCAN: begin
        if (i_r == cnt_r) begin
          state_nxt = S_CMP_TOP;
        end else begin
          if (rd_ent.used) begin
            wr_en        = 1'b1;
            wr_idx       = w_r[IW-1:0];
            wr_ent       = rd_ent;
            wr_ent.base  = addr_r[ADDR_BITS-1:0];
            addr_nxt     = addr_r + rd_ent.len;
            w_nxt        = w_r + CW'(1);
          end
          i_nxt = i_r + CW'(1);
        end
      end

      S_CMP_TOP: begin
        res_nxt.status = ST_OK;
        cnt_nxt = w_r;
        if (addr_r < mem_size_r && w_r < CW'(MAX_SEGMENTS)) begin
          wr_en       = 1'b1;
          wr_idx      = w_r[IW-1:0];
          wr_ent.base = addr_r[ADDR_BITS-1:0];
          wr_ent.len  = mem_size_r - addr_r;
          cnt_nxt     = w_r + CW'(1);
          res_nxt.seg_start = addr_r[ADDR_BITS-1:0];
          res_nxt.seg_end   = seg_last('0, mem_size_r);
        end
        state_nxt = S_EMIT;
      end

      S_LIST: begin
        if (out_free) begin
          out_ld = 1'b1;
          out_ld_data.status      = ST_OK;
          out_ld_data.seg_start   = rd_ent.base;
          out_ld_data.seg_end     = seg_last(rd_ent.base, rd_ent.len);
          out_ld_data.seg_owner   = rd_ent.owner;
          out_ld_data.seg_in_use  = rd_ent.used;
          out_ld_data.last_result = (i_r + CW'(1) == list_n);
          if (i_r + CW'(1) == list_n) state_nxt = S_IDLE;
          else i_nxt = i_r + CW'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= CW'(1);
      mem_size_r  <= MEM_SIZE_RST;
      tbl_r[0]    <= '{base: '0, len: MEM_SIZE_RST, owner: '0, used: 1'b0};
    end else begin
      state_r <= state_nxt;
      if (out_ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        // reset the table to one hole
        mem_size_r <= cfg_sat;
        cnt_r      <= CW'(1);
        tbl_r[0]   <= '{base: '0, len: cfg_sat, owner: '0, used: 1'b0};
      end else begin
        cnt_r <= cnt_nxt;
        if (wr_en) tbl_r[wr_idx] <= wr_ent;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    w_r         <= w_nxt;
    pick_r      <= pick_nxt;
    pick_base_r <= pick_base_nxt;
    pick_len_r  <= pick_len_nxt;
    found_r     <= found_nxt;
    close_lo_r  <= close_lo_nxt;
    addr_r      <= addr_nxt;
    res_r       <= res_nxt;
    if (out_ld) out_r <= out_ld_data;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= CW'(1) && cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_r[0].base == '0)
    else $error("first segment does not start at zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block ready right after accepting a command");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule
